[design/assert_macros.svh]
// assertion macros used by the dedup table design
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, disabled during reset
`define CHK_NOW(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication, disabled during reset
`define CHK_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

[design/mddt_pkg.sv]
// constants and types for the masked descriptor dedup table
package mddt_pkg;

	localparam int ENTRIES = 128;
	localparam int IDX_W   = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
	localparam int CNT_W   = $clog2(ENTRIES + 1);
	localparam int DATA_W  = 32;
	localparam int SLOT_W  = 7;
	localparam int STAT_W  = 2;

	localparam logic [STAT_W-1:0] STATUS_MERGED   = 2'd0;
	localparam logic [STAT_W-1:0] STATUS_APPENDED = 2'd1;
	localparam logic [STAT_W-1:0] STATUS_FULL     = 2'd2;

	typedef struct packed {
		logic [DATA_W-1:0] value;
		logic [DATA_W-1:0] mask;
	} entry_t;

endpackage

[design/masked_descriptor_dedup_table.sv]
// masked descriptor dedup table: sequential scan over one table memory
// scan: entries are compared in order, one per memory read, up to the first compatible one; empty table: no scan
// requests: a new word is accepted only in idle, not while a word is scanned or its result is held
// reset: arst_n clears fill count, state machine and output valid; table contents are not
//   cleared since entries at or above the fill count are never compared
`include "assert_macros.svh"

module masked_descriptor_dedup_table
	import mddt_pkg::*;
(
	input  logic              clk,
	input  logic              arst_n,
	input  logic              req_valid,
	output logic              req_ready,
	input  logic [DATA_W-1:0] desc_value,
	input  logic [DATA_W-1:0] care_mask,
	output logic              rsp_valid,
	input  logic              rsp_ready,
	output logic [SLOT_W-1:0] slot_index,
	output logic [STAT_W-1:0] status
);

	// controller states
	localparam logic [1:0] S_IDLE = 2'd0;
	localparam logic [1:0] S_SCAN = 2'd1;
	localparam logic [1:0] S_HOLD = 2'd2;

	// table memory: value and mask side by side, one read and one write port
	entry_t mem [ENTRIES];
	entry_t rdata_s1;

	logic [1:0]        state_q, state_d;
	logic [CNT_W-1:0]  fill_q;
	logic [IDX_W-1:0]  cmp_idx_q, cmp_idx_d;
	logic [DATA_W-1:0] value_q, mask_q;

	// finished result waiting for the output register
	logic [SLOT_W-1:0] hold_slot_q;
	logic [STAT_W-1:0] hold_status_q;

	logic              rsp_valid_q;
	logic [SLOT_W-1:0] slot_index_q;
	logic [STAT_W-1:0] status_q;

	// scan-side signals
	logic              wr_en;
	logic [IDX_W-1:0]  wr_addr;
	entry_t            wr_data;
	logic [IDX_W-1:0]  rd_addr;
	logic              fin;
	logic [SLOT_W-1:0] fin_slot;
	logic [STAT_W-1:0] fin_status;
	logic              fill_inc;
	logic              out_free;
	logic [DATA_W-1:0] both;
	logic              compat;
	logic              last_entry;
	logic              table_full;

	assign req_ready = (state_q == S_IDLE);
	assign out_free  = !rsp_valid_q || rsp_ready;

	// compatibility of the word under scan with the entry just read
	assign both       = mask_q & rdata_s1.mask;
	assign compat     = ((value_q ^ rdata_s1.value) & both) == '0;
	assign last_entry = (CNT_W'(cmp_idx_q) + 1'b1) == fill_q;
	assign table_full = fill_q == CNT_W'(ENTRIES);

	// read the next entry while the current one is compared
	assign rd_addr = (state_q == S_SCAN) ? IDX_W'(cmp_idx_q + 1'b1) : '0;

	always_comb begin
		state_d    = state_q;
		cmp_idx_d  = cmp_idx_q;
		wr_en      = 1'b0;
		wr_addr    = cmp_idx_q;
		wr_data    = rdata_s1;
		fin        = 1'b0;
		fin_slot   = '0;
		fin_status = STATUS_MERGED;
		fill_inc   = 1'b0;
		unique case (state_q)
			S_IDLE: begin
				if (req_valid) begin
					if (fill_q == '0) begin
						// empty table: append at entry zero right away
						wr_en      = 1'b1;
						wr_addr    = '0;
						wr_data    = '{value: desc_value, mask: care_mask};
						fin        = 1'b1;
						fin_status = STATUS_APPENDED;
						fill_inc   = 1'b1;
					end else begin
						state_d   = S_SCAN;
						cmp_idx_d = '0;
					end
				end
			end
			S_SCAN: begin
				if (compat) begin
					// merge: new-only bits go into value, masks combine
					wr_en         = 1'b1;
					wr_addr       = cmp_idx_q;
					wr_data.value = rdata_s1.value | (value_q & mask_q & ~rdata_s1.mask);
					wr_data.mask  = rdata_s1.mask | mask_q;
					fin           = 1'b1;
					// slot numbers are as wide as an entry index
					fin_slot      = SLOT_W'(cmp_idx_q);
					fin_status    = STATUS_MERGED;
				end else if (last_entry) begin
					fin = 1'b1;
					if (table_full) begin
						fin_slot   = '0;
						fin_status = STATUS_FULL;
					end else begin
						wr_en      = 1'b1;
						wr_addr    = fill_q[IDX_W-1:0];
						wr_data    = '{value: value_q, mask: mask_q};
						fin_slot   = SLOT_W'(fill_q);
						fin_status = STATUS_APPENDED;
						fill_inc   = 1'b1;
					end
				end else begin
					cmp_idx_d = IDX_W'(cmp_idx_q + 1'b1);
				end
			end
			S_HOLD: begin
				if (out_free) begin
					state_d = S_IDLE;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
		if (fin) begin
			state_d = out_free ? S_IDLE : S_HOLD;
		end
	end

	// table memory, registered read
	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
		rdata_s1 <= mem[rd_addr];
	end

	// control state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			fill_q      <= '0;
			cmp_idx_q   <= '0;
			rsp_valid_q <= 1'b0;
		end else begin
			state_q   <= state_d;
			cmp_idx_q <= cmp_idx_d;
			if (fill_inc) begin
				fill_q <= CNT_W'(fill_q + 1'b1);
			end
			if ((fin || state_q == S_HOLD) && out_free) begin
				rsp_valid_q <= 1'b1;
			end else if (rsp_ready) begin
				rsp_valid_q <= 1'b0;
			end
		end
	end

	// payload registers
	always_ff @(posedge clk) begin
		if (req_valid && req_ready) begin
			value_q <= desc_value;
			mask_q  <= care_mask;
		end
		if (fin && !out_free) begin
			hold_slot_q   <= fin_slot;
			hold_status_q <= fin_status;
		end
		if (fin && out_free) begin
			slot_index_q <= fin_slot;
			status_q     <= fin_status;
		end else if (state_q == S_HOLD && out_free) begin
			slot_index_q <= hold_slot_q;
			status_q     <= hold_status_q;
		end
	end

	assign rsp_valid  = rsp_valid_q;
	assign slot_index = slot_index_q;
	assign status     = status_q;

	// fill count stays within the table
	`CHK_NOW(a_fill_range, 1'b1, fill_q <= CNT_W'(ENTRIES), "fill count beyond table size")

	// the scan never compares an entry at or above the fill count
	`CHK_NOW(a_scan_in_range, state_q == S_SCAN, CNT_W'(cmp_idx_q) < fill_q, "scan past fill count")

	// a held result means the output register is still occupied
	`CHK_NOW(a_hold_busy, state_q == S_HOLD, rsp_valid_q, "result held with free output")

	// every append grows the table by exactly one entry
	`CHK_NEXT(a_append_grows, fin && fin_status == STATUS_APPENDED,
		fill_q == CNT_W'($past(fill_q) + 1'b1), "append without fill increment")

	// full status only when the table really is full
	`CHK_NOW(a_full_only_full, fin && fin_status == STATUS_FULL, table_full, "full reported early")

endmodule

[tb/masked_descriptor_dedup_table_tb.sv]
// testbench for the masked descriptor dedup table: directed, random, stall and full-table words
module masked_descriptor_dedup_table_tb;
	timeunit 1ns;
	timeprecision 1ps;

	import mddt_pkg::*;

	// generous cycle budget, far above the slowest correct run
	localparam int CYCLE_LIMIT = 1_000_000;

	// one expected response word
	typedef struct packed {
		logic [SLOT_W-1:0] slot;
		logic [STAT_W-1:0] stat;
	} lookup_result_t;

	logic              clk        = 1'b0;
	logic              arst_n     = 1'b0;
	logic              req_valid  = 1'b0;
	logic              req_ready;
	logic [DATA_W-1:0] desc_value = '0;
	logic [DATA_W-1:0] care_mask  = '0;
	logic              rsp_valid;
	logic              rsp_ready  = 1'b0;
	logic [SLOT_W-1:0] slot_index;
	logic [STAT_W-1:0] status;

	// mirror of the table contents, kept in step with accepted request words
	logic [DATA_W-1:0] mirror_value [ENTRIES];
	logic [DATA_W-1:0] mirror_mask  [ENTRIES];
	int                mirror_fill = 0;

	// responses still owed by the block, oldest first
	lookup_result_t pending_results [$];

	int cycle_count  = 0;
	int fail_count   = 0;
	int words_sent   = 0;
	int merged_cnt   = 0;
	int appended_cnt = 0;
	int full_cnt     = 0;

	// idle odds in percent for each side
	int send_idle_pct = 0;
	int recv_idle_pct = 0;

	// long receiver hold-off, requested by the test and counted by the receiver
	int hold_len  = 0;
	int hold_req  = 0;
	int hold_seen = 0;
	int hold_left = 0;

	masked_descriptor_dedup_table i_dut (
		.clk        (clk),
		.arst_n     (arst_n),
		.req_valid  (req_valid),
		.req_ready  (req_ready),
		.desc_value (desc_value),
		.care_mask  (care_mask),
		.rsp_valid  (rsp_valid),
		.rsp_ready  (rsp_ready),
		.slot_index (slot_index),
		.status     (status)
	);

	// 8 ns clock
	always #4 clk = ~clk;

	// watchdog
	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("simulation failed");
			$finish;
		end
	end

	task automatic report_mismatch(input string what);
		$display("mismatch at cycle %0d: %s", cycle_count, what);
		fail_count++;
	endtask

	// first filled entry compatible with the word, or -1
	function automatic int find_slot(input logic [DATA_W-1:0] value,
			input logic [DATA_W-1:0] mask);
		logic [DATA_W-1:0] both;
		for (int i = 0; i < mirror_fill; i++) begin
			both = mask & mirror_mask[i];
			if ((value & both) == (mirror_value[i] & both))
				return i;
		end
		return -1;
	endfunction

	// expected response for one accepted word; updates the mirror
	function automatic lookup_result_t predict_lookup(input logic [DATA_W-1:0] value,
			input logic [DATA_W-1:0] mask);
		lookup_result_t    res;
		int                hit;
		logic [DATA_W-1:0] both;
		hit = find_slot(value, mask);
		if (hit >= 0) begin
			// only bits new to the entry are ORed in, stale bits stay
			both = mask & mirror_mask[hit];
			mirror_value[hit] = mirror_value[hit] | (value & (mask ^ both));
			mirror_mask[hit]  = mirror_mask[hit] | mask;
			res.slot = SLOT_W'(hit);
			res.stat = STATUS_MERGED;
			merged_cnt++;
		end else if (mirror_fill >= ENTRIES) begin
			// table full: nothing changes
			res.slot = '0;
			res.stat = STATUS_FULL;
			full_cnt++;
		end else begin
			mirror_value[mirror_fill] = value;
			mirror_mask[mirror_fill]  = mask;
			res.slot = SLOT_W'(mirror_fill);
			res.stat = STATUS_APPENDED;
			mirror_fill++;
			appended_cnt++;
		end
		return res;
	endfunction

	// value that agrees with entry k on all its fixed bits
	function automatic logic [DATA_W-1:0] derive_value(input int k);
		logic [DATA_W-1:0] noise;
		noise = $urandom;
		return (mirror_value[k] & mirror_mask[k]) | (noise & ~mirror_mask[k]);
	endfunction

	// full-mask value that clashes with every filled entry, when one is found
	function automatic logic [DATA_W-1:0] pick_fresh_value();
		logic [DATA_W-1:0] v;
		v = $urandom;
		for (int t = 0; t < 4000 && find_slot(v, '1) >= 0; t++)
			v = $urandom;
		return v;
	endfunction

	function automatic logic [DATA_W-1:0] pick_mask();
		logic [DATA_W-1:0] m;
		case ($urandom_range(0, 7))
			0: begin
				m = '0;
			end
			1: begin
				m = '1;
			end
			2: begin
				m = $urandom & $urandom;
			end
			3: begin
				m = 32'h1 << $urandom_range(0, 31);
			end
			default: begin
				m = $urandom;
			end
		endcase
		return m;
	endfunction

	// offers one request word; starts and ends at a falling edge
	task automatic send_word(input logic [DATA_W-1:0] value, input logic [DATA_W-1:0] mask);
		while ($urandom_range(0, 99) < send_idle_pct) begin
			req_valid <= 1'b0;
			@(negedge clk);
		end
		req_valid  <= 1'b1;
		desc_value <= value;
		care_mask  <= mask;
		@(posedge clk);
		while (!req_ready)
			@(posedge clk);
		// accepted at this edge
		pending_results = {pending_results, predict_lookup(value, mask)};
		words_sent++;
		@(negedge clk);
	endtask

	// receiver: random stalls, or a long hold-off when one is requested
	always @(negedge clk) begin
		if (hold_seen != hold_req) begin
			hold_seen = hold_req;
			hold_left = hold_len;
		end
		if (hold_left > 0) begin
			hold_left--;
			rsp_ready <= 1'b0;
		end else begin
			rsp_ready <= ($urandom_range(0, 99) >= recv_idle_pct);
		end
	end

	// response checker: each word against the oldest expectation
	always @(posedge clk) begin : check_response
		lookup_result_t want;
		if (arst_n && rsp_valid && rsp_ready) begin
			if (pending_results.size() == 0) begin
				report_mismatch($sformatf("response with nothing pending (slot %0d status %0d)",
					slot_index, status));
			end else begin
				want = pending_results.pop_front();
				if (slot_index !== want.slot)
					report_mismatch($sformatf("slot_index %0d, wanted %0d",
						slot_index, want.slot));
				if (status !== want.stat)
					report_mismatch($sformatf("status %0d, wanted %0d", status, want.stat));
			end
		end
	end

	// extremes, zero mask, stale bits and single-bit masks on a fresh table
	task automatic test_directed();
		send_idle_pct = 0;
		recv_idle_pct = 0;
		send_word(32'hFFFF_FFFF, 32'h0000_0000);  // zero mask on empty table appends
		send_word(32'h0000_0000, 32'h0000_0000);  // zero mask merges into entry 0
		send_word(32'h0000_0000, 32'hFFFF_FFFF);  // merges, stale ones stay in entry 0
		send_word(32'h0000_0000, 32'hFFFF_FFFF);  // now clashes with entry 0
		send_word(32'hFFFF_FFFF, 32'hFFFF_FFFF);
		send_word(32'hFFFF_FFFF, 32'hFFFF_FFFF);
		send_word(32'h0000_0000, 32'h0000_0000);
		send_word(32'hA5A5_A5A5, 32'h0000_FFFF);
		send_word(32'hA5A5_0000, 32'hFFFF_0000);  // disjoint masks merge
		send_word(32'hA5A5_A5A5, 32'hFFFF_FFFF);
		send_word(32'h0000_0001, 32'h0000_0001);
		send_word(32'h0000_0000, 32'h8000_0000);
		send_word(32'h5555_5555, 32'hAAAA_AAAA);
		send_word(32'hAAAA_AAAA, 32'h5555_5555);
		send_word(32'h8000_0000, 32'h8000_0000);
		send_word(32'h1234_5678, 32'hFFFF_FFFF);
		send_word(32'h1234_5678, 32'h0F0F_0F0F);
		send_word(32'hEDCB_A987, 32'hFFFF_FFFF);
	endtask

	// mostly words built to hit a filled entry, some fresh words and noise
	task automatic test_random_mix(input int count, input int send_pct, input int recv_pct);
		int                roll;
		int                k;
		logic [DATA_W-1:0] v;
		logic [DATA_W-1:0] m;
		send_idle_pct = send_pct;
		recv_idle_pct = recv_pct;
		repeat (count) begin
			roll = $urandom_range(0, 99);
			if (mirror_fill != 0 && roll < 80) begin
				k = $urandom_range(0, mirror_fill - 1);
				v = derive_value(k);
				m = pick_mask();
			end else if (roll < 90) begin
				v = $urandom;
				m = '1;
			end else begin
				v = $urandom;
				m = pick_mask();
			end
			send_word(v, m);
		end
	endtask

	// receiver stalls long while the sender keeps offering
	task automatic test_backpressure();
		send_idle_pct = 0;
		recv_idle_pct = 0;
		hold_len = 400;
		hold_req++;
		repeat (24)
			send_word(derive_value($urandom_range(0, mirror_fill - 1)), pick_mask());
	endtask

	// fill the table, then clashing words see the full status
	task automatic test_table_full();
		int n;
		send_idle_pct = 20;
		recv_idle_pct = 20;
		n = 0;
		while (mirror_fill < ENTRIES && n < 4 * ENTRIES) begin
			send_word(pick_fresh_value(), '1);
			n++;
		end
		repeat (6)
			send_word(pick_fresh_value(), '1);
		send_word($urandom, '0);  // zero mask still merges into entry 0
		send_word(derive_value(ENTRIES - 1), pick_mask());
		send_word(derive_value(ENTRIES - 1), '1);
	endtask

	initial begin
		// reset held at the start, then released at a falling edge
		repeat (3) @(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		test_directed();
		test_random_mix(180, 20, 68);
		test_random_mix(180, 68, 20);
		test_random_mix(180, 0, 0);
		test_backpressure();
		test_table_full();
		req_valid <= 1'b0;

		// drain, then allow one worst-case scan more
		while (pending_results.size() != 0)
			@(posedge clk);
		repeat (2 * ENTRIES + 16) @(posedge clk);

		$display("run covered %0d request words: %0d merged, %0d appended, %0d table full",
			words_sent, merged_cnt, appended_cnt, full_cnt);
		$display("table reached %0d of %0d entries, %0d mismatches, %0d cycles",
			mirror_fill, ENTRIES, fail_count, cycle_count);
		if (fail_count == 0) begin
			$display("simulation ok");
		end else begin
			$display("simulation failed");
		end
		$finish;
	end

endmodule
